@@ src/rpwd_pkg.sv @@
// Shared types, constants and register codes for the RC pulse width decoder.
package rpwd_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = 2;
  localparam int DUTY_W       = 16;
  localparam int APB_AW       = 5;
  localparam int APB_DW       = 32;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;

  typedef enum logic [CH_W-1:0] {
    CH_STEER = 2'd0,
    CH_MOTOR = 2'd1,
    CH_MODE  = 2'd2,
    CH_NONE  = 2'd3
  } channel_t;

  typedef enum logic [2:0] {
    REG_DUTY_FLOOR    = 3'd0,
    REG_DUTY_CEILING  = 3'd1,
    REG_DUTY_CAP      = 3'd2,
    REG_CENTER_OFFSET = 3'd3,
    REG_TIMER_PERIOD  = 3'd4
  } reg_idx_t;

  localparam logic [DUTY_W-1:0] MODE_OFF_LO = 16'd800;
  localparam logic [DUTY_W-1:0] MODE_OFF_HI = 16'd1300;
  localparam logic [DUTY_W-1:0] MODE_ON_LO  = 16'd1400;
  localparam logic [DUTY_W-1:0] MODE_ON_HI  = 16'd2200;

  localparam logic [DUTY_W-1:0] DUTY_FLOOR_RST    = 16'd1000;
  localparam logic [DUTY_W-1:0] DUTY_CEILING_RST  = 16'd2000;
  localparam logic [DUTY_W-1:0] DUTY_CAP_RST      = 16'd1800;
  localparam logic [DUTY_W-1:0] CENTER_OFFSET_RST = 16'd0;
  localparam logic [DUTY_W-1:0] TIMER_PERIOD_RST  = 16'd5000;

  typedef struct packed {
    logic [DUTY_W-1:0]        timer_period;
    logic signed [DUTY_W-1:0] center_offset;
    logic [DUTY_W-1:0]        duty_cap;
    logic [DUTY_W-1:0]        duty_ceiling;
    logic [DUTY_W-1:0]        duty_floor;
  } cfg_t;

  // Lowest field last, so it lands in the lowest bits.
  typedef struct packed {
    logic [DUTY_W-1:0] timestamp;
    logic              level;
    logic [CH_W-1:0]   channel;
  } in_item_t;

  typedef struct packed {
    logic              remote_mode;
    logic [DUTY_W-1:0] motor_duty;
    logic              motor_valid;
    logic [DUTY_W-1:0] steer_duty;
    logic              steer_valid;
  } out_item_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int OUT_ITEM_W = $bits(out_item_t);

endpackage

@@ src/rpwd_apb_regs.sv @@
// APB configuration register file for the RC pulse width decoder.
module rpwd_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpwd_pkg::APB_AW-1:0] paddr,
  input  logic [rpwd_pkg::APB_DW-1:0] pwdata,
  output logic [rpwd_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output rpwd_pkg::cfg_t              cfg
);
  import rpwd_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_floor    <= DUTY_FLOOR_RST;
      cfg.duty_ceiling  <= DUTY_CEILING_RST;
      cfg.duty_cap      <= DUTY_CAP_RST;
      cfg.center_offset <= CENTER_OFFSET_RST;
      cfg.timer_period  <= TIMER_PERIOD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DUTY_FLOOR:    cfg.duty_floor    <= pwdata[DUTY_W-1:0];
        REG_DUTY_CEILING:  cfg.duty_ceiling  <= pwdata[DUTY_W-1:0];
        REG_DUTY_CAP:      cfg.duty_cap      <= pwdata[DUTY_W-1:0];
        REG_CENTER_OFFSET: cfg.center_offset <= pwdata[DUTY_W-1:0];
        REG_TIMER_PERIOD:  cfg.timer_period  <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DUTY_FLOOR:    prdata[DUTY_W-1:0] = cfg.duty_floor;
      REG_DUTY_CEILING:  prdata[DUTY_W-1:0] = cfg.duty_ceiling;
      REG_DUTY_CAP:      prdata[DUTY_W-1:0] = cfg.duty_cap;
      REG_CENTER_OFFSET: prdata[DUTY_W-1:0] = cfg.center_offset;
      REG_TIMER_PERIOD:  prdata[DUTY_W-1:0] = cfg.timer_period;
      default:           prdata = '0;
    endcase
  end

endmodule

@@ src/rpwd_decode.sv @@
// Width measurement, mode tracking and duty checks; holds the per-channel edge state.
module rpwd_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 commit,
  input  rpwd_pkg::in_item_t   item,
  input  rpwd_pkg::cfg_t       cfg,
  output rpwd_pkg::out_item_t  result
);
  import rpwd_pkg::*;

  logic [DUTY_W-1:0] rise_stamp [NUM_CHANNELS];
  logic              remote_enable;
  logic              remote_enable_next;

  logic              ch_ok;
  logic [DUTY_W-1:0] start;
  logic [DUTY_W-1:0] diff;
  logic [DUTY_W-1:0] width;
  logic signed [DUTY_W+1:0] steer_val;
  logic signed [DUTY_W+1:0] min_s;
  logic signed [DUTY_W+1:0] max_s;
  logic              falling;

  assign ch_ok   = item.channel < CH_W'(NUM_CHANNELS);
  assign start   = ch_ok ? rise_stamp[item.channel] : '0;
  assign diff    = item.timestamp - start;
  // Wrap back into range when the stamp did not move forward.
  assign width   = (item.timestamp > start) ? diff : diff + cfg.timer_period;
  assign falling = ch_ok && !item.level;

  assign steer_val = $signed({2'b00, width}) - (DUTY_W+2)'(cfg.center_offset);
  assign min_s     = $signed({2'b00, cfg.duty_floor});
  assign max_s     = $signed({2'b00, cfg.duty_ceiling});

  always_comb begin
    remote_enable_next = remote_enable;
    result             = '0;
    if (falling) begin
      unique case (channel_t'(item.channel))
        CH_MODE: begin
          if (width > MODE_OFF_LO && width < MODE_OFF_HI) begin
            remote_enable_next = 1'b0;
          end else if (width > MODE_ON_LO && width < MODE_ON_HI) begin
            remote_enable_next = 1'b1;
          end
        end
        CH_STEER: begin
          if (remote_enable && steer_val < max_s && steer_val > min_s) begin
            result.steer_valid = 1'b1;
            result.steer_duty  = steer_val[DUTY_W-1:0];
          end
        end
        CH_MOTOR: begin
          if (remote_enable && width < cfg.duty_ceiling && width > cfg.duty_floor) begin
            result.motor_valid = 1'b1;
            result.motor_duty  = (width > cfg.duty_cap) ? cfg.duty_cap : width;
          end
        end
        default: ;
      endcase
    end
    result.remote_mode = remote_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_enable <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_stamp[i] <= '0;
      end
    end else if (commit) begin
      remote_enable <= remote_enable_next;
      if (ch_ok && item.level) begin
        rise_stamp[item.channel] <= item.timestamp;
      end
    end
  end

endmodule

@@ src/rc_pulse_width_decoder.sv @@
// Top level of the RC pulse width decoder: input register, decode, result register, APB.
//
//  channel  dir  handshake           payload
//  s_axis   in   s_tvalid/s_tready   s_tdata: edge event
//  m_axis   out  m_tvalid/m_tready   m_tdata: duties and remote mode
//  apb      in   psel/penable/pready 5 registers at 4*index
//
// Each request passes through the input register, then the decode logic feeds
// the result register. One request per cycle is sustained while m_tready is high.
// Reset clears the edge stamps, remote mode and both valid flags and loads the
// register defaults. When m_tready is low the result holds and the input register
// still takes one more request before s_tready drops.
module rc_pulse_width_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [1:0] channel, [2] level, [18:3] timestamp, rest zero
  input  logic [rpwd_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] steer_valid, [16:1] steer_duty, [17] motor_valid, [33:18] motor_duty,
  // [34] remote_mode, rest zero
  output logic [rpwd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rpwd_pkg::APB_AW-1:0]      paddr,
  input  logic [rpwd_pkg::APB_DW-1:0]      pwdata,
  output logic [rpwd_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import rpwd_pkg::*;

  cfg_t      cfg;
  in_item_t  in_reg;
  logic      in_valid;
  out_item_t result;
  out_item_t out_reg;
  logic      advance;

  rpwd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the held request into the result register when that slot frees up.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
    end
  end

  rpwd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {(OUT_TDATA_W-OUT_ITEM_W)'(0), out_reg};

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the RC pulse width decoder: edge streams against a duty predictor.
module tb;
  import rpwd_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;

  // Predicts the decoder's output per edge request and checks results in order.
  class duty_tracker;
    cfg_t              cfg;
    logic [DUTY_W-1:0] rise_at [NUM_CHANNELS];
    bit                remote_on;
    out_item_t         expected_duties [$];
    int unsigned       fails, edges, results, steer_hits, motor_hits;

    function new();
      cfg.duty_floor    = DUTY_FLOOR_RST;
      cfg.duty_ceiling  = DUTY_CEILING_RST;
      cfg.duty_cap      = DUTY_CAP_RST;
      cfg.center_offset = CENTER_OFFSET_RST;
      cfg.timer_period  = TIMER_PERIOD_RST;
      foreach (rise_at[i]) rise_at[i] = '0;
      remote_on  = 1'b0;
      fails      = 0;
      edges      = 0;
      results    = 0;
      steer_hits = 0;
      motor_hits = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      fails++;
    endtask

    function void apply_reg(int unsigned idx, logic [APB_DW-1:0] word);
      case (idx)
        REG_DUTY_FLOOR:    cfg.duty_floor    = word[DUTY_W-1:0];
        REG_DUTY_CEILING:  cfg.duty_ceiling  = word[DUTY_W-1:0];
        REG_DUTY_CAP:      cfg.duty_cap      = word[DUTY_W-1:0];
        REG_CENTER_OFFSET: cfg.center_offset = word[DUTY_W-1:0];
        REG_TIMER_PERIOD:  cfg.timer_period  = word[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DUTY_W-1:0] reg_value(int unsigned idx);
      case (idx)
        REG_DUTY_FLOOR:    return cfg.duty_floor;
        REG_DUTY_CEILING:  return cfg.duty_ceiling;
        REG_DUTY_CAP:      return cfg.duty_cap;
        REG_CENTER_OFFSET: return cfg.center_offset;
        REG_TIMER_PERIOD:  return cfg.timer_period;
        default:           return '0;
      endcase
    endfunction

    function void note_edge(in_item_t it);
      out_item_t         res;
      logic [DUTY_W-1:0] w;
      int                diff;
      int                trimmed;
      int                ch;
      res = '0;
      ch  = int'(it.channel);
      edges++;
      if (it.channel != CH_NONE) begin
        if (it.level) begin
          rise_at[ch] = it.timestamp;
        end else begin
          diff = int'(it.timestamp) - int'(rise_at[ch]);
          // non-positive difference: the timer wrapped, add one period and keep 16 bits
          if (diff <= 0) diff = diff + int'(cfg.timer_period);
          w = diff[DUTY_W-1:0];
          if (it.channel == CH_MODE) begin
            if (w > MODE_OFF_LO && w < MODE_OFF_HI) remote_on = 1'b0;
            else if (w > MODE_ON_LO && w < MODE_ON_HI) remote_on = 1'b1;
          end else if (it.channel == CH_STEER) begin
            trimmed = int'(w) - int'($signed(cfg.center_offset));
            if (remote_on && trimmed > int'(cfg.duty_floor) &&
                trimmed < int'(cfg.duty_ceiling)) begin
              res.steer_valid = 1'b1;
              res.steer_duty  = trimmed[DUTY_W-1:0];
            end
          end else begin
            if (remote_on && w > cfg.duty_floor && w < cfg.duty_ceiling) begin
              res.motor_valid = 1'b1;
              res.motor_duty  = (w > cfg.duty_cap) ? cfg.duty_cap : w;
            end
          end
        end
      end
      res.remote_mode = remote_on;
      expected_duties.push_back(res);
    endfunction

    task check_duty(logic [OUT_TDATA_W-1:0] raw);
      out_item_t want;
      out_item_t got;
      results++;
      got = raw[OUT_ITEM_W-1:0];
      if (expected_duties.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected: %h", results, raw));
        return;
      end
      want = expected_duties.pop_front();
      if (got.steer_valid !== want.steer_valid)
        report($sformatf("result %0d steer_valid got %b want %b",
                         results, got.steer_valid, want.steer_valid));
      if (got.steer_duty !== want.steer_duty)
        report($sformatf("result %0d steer_duty got %0d want %0d",
                         results, got.steer_duty, want.steer_duty));
      if (got.motor_valid !== want.motor_valid)
        report($sformatf("result %0d motor_valid got %b want %b",
                         results, got.motor_valid, want.motor_valid));
      if (got.motor_duty !== want.motor_duty)
        report($sformatf("result %0d motor_duty got %0d want %0d",
                         results, got.motor_duty, want.motor_duty));
      if (got.remote_mode !== want.remote_mode)
        report($sformatf("result %0d remote_mode got %b want %b",
                         results, got.remote_mode, want.remote_mode));
      if (raw[OUT_TDATA_W-1:OUT_ITEM_W] !== '0)
        report($sformatf("result %0d padding bits not zero: %h", results, raw));
      if (want.steer_valid) steer_hits++;
      if (want.motor_valid) motor_hits++;
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  duty_tracker tracker;
  int          tx_gap_max;
  int          rx_gap_max;
  bit          rx_hold_req;
  int          settings_run;
  int          stall_cycles = 0;

  rc_pulse_width_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if no request, result or register access moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_edge(logic [CH_W-1:0] ch, logic lvl, logic [DUTY_W-1:0] ts);
    in_item_t it;
    int       gap;
    it.channel   = ch;
    it.level     = lvl;
    it.timestamp = ts;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-IN_ITEM_W){1'b0}}, it};
    do @(posedge clk); while (!s_tready);
    tracker.note_edge(it);
  endtask

  task automatic edge_pair(logic [CH_W-1:0] ch, logic [DUTY_W-1:0] rise_ts,
                           logic [DUTY_W-1:0] fall_ts);
    send_edge(ch, 1'b1, rise_ts);
    send_edge(ch, 1'b0, fall_ts);
  endtask

  // Hold the input low and wait until every expected result has been taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.expected_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic drain_duties();
    int gap;
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (rx_hold_req) begin
        gap = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      tracker.check_duty(m_tdata);
    end
  endtask

  task automatic apb_access(logic wr, int unsigned idx, logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    logic [31:0] addr;
    addr = 4 * idx;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr[APB_AW-1:0];
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(int unsigned idx);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd[DUTY_W-1:0] !== tracker.reg_value(idx))
      tracker.report($sformatf("register %0d read %h want %h",
                               idx, rd[DUTY_W-1:0], tracker.reg_value(idx)));
  endtask

  task automatic set_reg(int unsigned idx, logic [DUTY_W-1:0] val);
    logic [APB_DW-1:0] word;
    logic [APB_DW-1:0] unused;
    // upper bits carry junk; only the low half is meaningful
    word = $urandom;
    word[DUTY_W-1:0] = val;
    apb_access(1'b1, idx, word, unused);
    tracker.apply_reg(idx, word);
    if (idx <= REG_TIMER_PERIOD) check_reg(idx);
  endtask

  function automatic logic [DUTY_W-1:0] pick_width(logic [CH_W-1:0] ch);
    logic [DUTY_W-1:0] jitter;
    int                pick;
    jitter = DUTY_W'($urandom_range(0, 4));
    jitter = jitter - 16'd2;
    pick   = $urandom_range(0, 9);
    if (ch == CH_MODE && pick < 5)
      return DUTY_W'($urandom_range(MODE_ON_LO + 1, MODE_ON_HI - 1));
    if (ch == CH_MODE && pick < 7)
      return DUTY_W'($urandom_range(MODE_OFF_LO + 1, MODE_OFF_HI - 1));
    case ($urandom_range(0, 7))
      0:       return DUTY_W'($urandom);
      1, 2:    return DUTY_W'($urandom_range(500, 2500));
      3: begin
        case ($urandom_range(0, 3))
          0:       return MODE_OFF_LO + jitter;
          1:       return MODE_OFF_HI + jitter;
          2:       return MODE_ON_LO + jitter;
          default: return MODE_ON_HI + jitter;
        endcase
      end
      4:       return tracker.cfg.duty_floor + jitter;
      5:       return tracker.cfg.duty_ceiling + jitter;
      6:       return tracker.cfg.duty_cap + jitter;
      default: return tracker.cfg.center_offset + jitter +
                      ($urandom_range(0, 1) ? tracker.cfg.duty_ceiling : tracker.cfg.duty_floor);
    endcase
  endfunction

  task automatic send_pulse(logic [CH_W-1:0] ch, logic [DUTY_W-1:0] w);
    logic [DUTY_W-1:0] rise_ts;
    logic [DUTY_W-1:0] fall_ts;
    int unsigned       per;
    per = tracker.cfg.timer_period;
    if (w != 0 && per > w && $urandom_range(0, 3) == 0) begin
      // place the pulse across the timer wrap
      rise_ts = DUTY_W'(per - 1 - $urandom_range(0, w - 1));
      fall_ts = DUTY_W'(int'(rise_ts) + int'(w) - int'(per));
    end else if ($urandom_range(0, 9) == 0) begin
      rise_ts = DUTY_W'($urandom);
      fall_ts = rise_ts + w;
    end else begin
      rise_ts = DUTY_W'($urandom_range(0, 65535 - w));
      fall_ts = rise_ts + w;
    end
    edge_pair(ch, rise_ts, fall_ts);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned       sent;
    int                pick;
    logic [CH_W-1:0]   ch;
    logic              lvl;
    logic [DUTY_W-1:0] ts;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // lone edge on any channel, the unused one included
        ch  = CH_W'($urandom_range(0, 3));
        lvl = 1'($urandom_range(0, 1));
        ts  = DUTY_W'($urandom);
        send_edge(ch, lvl, ts);
        sent += 1;
      end else begin
        if (pick < 40) ch = CH_MODE;
        else if (pick < 70) ch = CH_STEER;
        else ch = CH_MOTOR;
        send_pulse(ch, pick_width(ch));
        sent += 2;
      end
      if ($urandom_range(0, 59) == 0) settle();
    end
  endtask

  task automatic run_directed();
    edge_pair(CH_NONE, 16'hFFFF, 16'h0000);  // unused channel
    edge_pair(CH_STEER, 16'd100, 16'd1700);  // remote mode off: nothing issued
    edge_pair(CH_MODE, 16'd10, 16'd1411);    // lowest width that sets remote mode
    edge_pair(CH_STEER, 16'd0, 16'd1001);    // just above the lower bound
    edge_pair(CH_STEER, 16'd0, 16'd2000);    // at the upper bound: dropped
    edge_pair(CH_MOTOR, 16'd0, 16'd1900);    // capped at the motor limit
    edge_pair(CH_MODE, 16'd0, 16'd2200);     // outside both windows: unchanged
    edge_pair(CH_MODE, 16'd0, 16'd1299);     // highest width that clears remote mode
    edge_pair(CH_MOTOR, 16'd0, 16'd1500);    // remote mode off again
    edge_pair(CH_MODE, 16'd0, 16'd2199);
    edge_pair(CH_STEER, 16'd3700, 16'd500);  // timer wrap
    edge_pair(CH_MOTOR, 16'd700, 16'd700);   // zero difference: one full period
    edge_pair(CH_MOTOR, 16'hFFFF, 16'h0000); // large negative difference
  endtask

  initial begin
    int unsigned idx;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    m_tready    <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    rst         <= 1'b1;
    tx_gap_max   = 0;
    rx_gap_max   = 0;
    rx_hold_req  = 1'b0;
    settings_run = 1;
    tracker      = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      drain_duties();
    join_none
    for (idx = 0; idx <= REG_TIMER_PERIOD; idx++) check_reg(idx);

    // reset settings, first with no idling on either side
    run_directed();
    tx_gap_max = 6;
    rx_gap_max = 6;
    run_random(100);
    settle();

    // widest window, zero cap, most negative trim, period that adds nothing
    set_reg(REG_DUTY_FLOOR, 16'd0);
    set_reg(REG_DUTY_CEILING, 16'hFFFF);
    set_reg(REG_DUTY_CAP, 16'd0);
    set_reg(REG_CENTER_OFFSET, 16'h8000);
    set_reg(REG_TIMER_PERIOD, 16'd0);
    settings_run++;
    run_random(100);
    settle();

    // empty window, most positive trim, longest period; no idling
    set_reg(REG_DUTY_FLOOR, 16'hFFFF);
    set_reg(REG_DUTY_CEILING, 16'd0);
    set_reg(REG_DUTY_CAP, 16'hFFFF);
    set_reg(REG_CENTER_OFFSET, 16'h7FFF);
    set_reg(REG_TIMER_PERIOD, 16'hFFFF);
    settings_run++;
    tx_gap_max = 0;
    rx_gap_max = 0;
    run_random(50);
    settle();

    // shortest non-zero period, steering only past half scale
    set_reg(REG_DUTY_FLOOR, 16'd0);
    set_reg(REG_DUTY_CEILING, 16'hFFFF);
    set_reg(REG_TIMER_PERIOD, 16'd1);
    settings_run++;
    tx_gap_max = 6;
    rx_gap_max = 6;
    run_random(100);
    settle();

    // random settings near the usual pulse range, plus a write to an unmapped index
    set_reg(REG_DUTY_FLOOR, DUTY_W'($urandom_range(0, 1500)));
    set_reg(REG_DUTY_CEILING, DUTY_W'($urandom_range(1500, 4000)));
    set_reg(REG_DUTY_CAP, DUTY_W'($urandom_range(0, 4000)));
    set_reg(REG_CENTER_OFFSET, DUTY_W'($urandom_range(0, 1200) - 600));
    set_reg(REG_TIMER_PERIOD, DUTY_W'($urandom_range(1, 65535)));
    set_reg(REG_TIMER_PERIOD + 1, DUTY_W'($urandom));
    settings_run++;
    run_random(180);
    settle();

    // back to reset values; hold the result side while requests keep coming
    set_reg(REG_DUTY_FLOOR, DUTY_FLOOR_RST);
    set_reg(REG_DUTY_CEILING, DUTY_CEILING_RST);
    set_reg(REG_DUTY_CAP, DUTY_CAP_RST);
    set_reg(REG_CENTER_OFFSET, CENTER_OFFSET_RST);
    set_reg(REG_TIMER_PERIOD, TIMER_PERIOD_RST);
    settings_run++;
    tx_gap_max  = 0;
    rx_hold_req = 1'b1;
    run_random(60);
    settle();
    tx_gap_max = 6;
    run_random(40);
    settle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d edge requests under %0d register settings,",
             tracker.edges, settings_run);
    $display("with %0d results checked: %0d steering and %0d motor duties issued.",
             tracker.results, tracker.steer_hits, tracker.motor_hits);
    if (tracker.fails == 0 && tracker.expected_duties.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
